>>> sv/lsx_pkg.sv
// ----------------------------------------------------------------------------
// lsx_pkg
// shared types and constants for the list store exchange sorter
// ----------------------------------------------------------------------------
package lsx_pkg;

    localparam int DATA_W = 32;
    localparam int FUNC_W = 2;

    localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SORT   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SHOW   = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SRT_RDI,
        ST_SRT_RDJ,
        ST_SRT_CMP,
        ST_SRT_WRI,
        ST_SHOW
    } t_state;

endpackage

>>> sv/list_store_exchange_sorter.sv
// ----------------------------------------------------------------------------
// list_store_exchange_sorter
// ordered list of signed values with append, in-place exchange sort and show
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  request   in         start & !busy      i_func, i_value
//  result    out        o_strobe (1 cycle) o_item, o_last, o_empty_res, o_full_res
//
//  append does not raise busy; a dropped append gives its result the next cycle
//  show holds busy while it reads out the entries, results follow one per cycle
//  sort does one compare per cycle within a pass, with read and write-back
//  states between passes, bounded by the single read port of the entry memory
//  synchronous active-low reset empties the list; memory contents are kept
//  results cannot be stalled by the receiver
// ----------------------------------------------------------------------------
module list_store_exchange_sorter #(
    parameter int CAPACITY = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [lsx_pkg::FUNC_W-1:0]        i_func,
    input  logic signed [lsx_pkg::DATA_W-1:0] i_value,
    output logic                              o_strobe,
    output logic signed [lsx_pkg::DATA_W-1:0] o_item,
    output logic                              o_last,
    output logic                              o_empty_res,
    output logic                              o_full_res
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    lsx_pkg::t_state r_state, n_state;

    logic [CW-1:0]                     r_count, n_count;
    logic [AW-1:0]                     r_i, n_i;
    logic [AW-1:0]                     r_jd, n_jd;
    logic [AW-1:0]                     r_k, n_k;
    logic signed [lsx_pkg::DATA_W-1:0] r_a, n_a;

    logic                              r_strobe, n_strobe;
    logic signed [lsx_pkg::DATA_W-1:0] r_item, n_item;
    logic                              r_last, n_last;
    logic                              r_empty, n_empty;
    logic                              r_full, n_full;

    logic                              mem_we;
    logic [AW-1:0]                     mem_waddr;
    logic [lsx_pkg::DATA_W-1:0]        mem_wdata;
    logic                              mem_re;
    logic [AW-1:0]                     mem_raddr;
    logic signed [lsx_pkg::DATA_W-1:0] rd_data;

    logic                              req;
    logic                              full;
    logic                              jd_more;
    logic                              i_more;
    logic                              k_last;

    lsx_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (rd_data)
    );

    assign busy    = (r_state != lsx_pkg::ST_IDLE);
    assign req     = start && !busy;
    assign full    = (r_count == CW'(CAPACITY));
    assign jd_more = ((CW'(r_jd) + CW'(1)) < r_count);
    assign i_more  = ((CW'(r_i) + CW'(2)) < r_count);
    assign k_last  = ((CW'(r_k) + CW'(1)) == r_count);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lsx_pkg::ST_IDLE: begin
                if (req) begin
                    if (i_func == lsx_pkg::FUNC_SORT && r_count >= CW'(2)) begin
                        n_state = lsx_pkg::ST_SRT_RDI;
                    end else if (i_func == lsx_pkg::FUNC_SHOW && r_count != '0) begin
                        n_state = lsx_pkg::ST_SHOW;
                    end
                end
            end
            lsx_pkg::ST_SRT_RDI: n_state = lsx_pkg::ST_SRT_RDJ;
            lsx_pkg::ST_SRT_RDJ: n_state = lsx_pkg::ST_SRT_CMP;
            lsx_pkg::ST_SRT_CMP: begin
                if (!jd_more) begin
                    n_state = lsx_pkg::ST_SRT_WRI;
                end
            end
            lsx_pkg::ST_SRT_WRI: begin
                n_state = i_more ? lsx_pkg::ST_SRT_RDI : lsx_pkg::ST_IDLE;
            end
            lsx_pkg::ST_SHOW: begin
                if (k_last) begin
                    n_state = lsx_pkg::ST_IDLE;
                end
            end
            default: n_state = lsx_pkg::ST_IDLE;
        endcase
    end

    // memory control, datapath and result
    always_comb begin
        n_count   = r_count;
        n_i       = r_i;
        n_jd      = r_jd;
        n_k       = r_k;
        n_a       = r_a;
        n_strobe  = 1'b0;
        n_item    = '0;
        n_last    = 1'b0;
        n_empty   = 1'b0;
        n_full    = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = r_count[AW-1:0];
        mem_wdata = i_value;
        mem_re    = 1'b0;
        mem_raddr = r_i;
        unique case (r_state)
            lsx_pkg::ST_IDLE: begin
                if (req) begin
                    case (i_func)
                        lsx_pkg::FUNC_APPEND: begin
                            if (full) begin
                                n_strobe = 1'b1;
                                n_full   = 1'b1;
                            end else begin
                                mem_we  = 1'b1;
                                n_count = r_count + CW'(1);
                            end
                        end
                        lsx_pkg::FUNC_SORT: begin
                            n_i = '0;
                        end
                        lsx_pkg::FUNC_SHOW: begin
                            if (r_count == '0) begin
                                n_strobe = 1'b1;
                                n_last   = 1'b1;
                                n_empty  = 1'b1;
                            end else begin
                                mem_re    = 1'b1;
                                mem_raddr = '0;
                                n_k       = '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            lsx_pkg::ST_SRT_RDI: begin
                mem_re    = 1'b1;
                mem_raddr = r_i;
            end
            lsx_pkg::ST_SRT_RDJ: begin
                n_a       = rd_data;
                mem_re    = 1'b1;
                mem_raddr = r_i + AW'(1);
                n_jd      = r_i + AW'(1);
            end
            lsx_pkg::ST_SRT_CMP: begin
                if (r_a > rd_data) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_jd;
                    mem_wdata = r_a;
                    n_a       = rd_data;
                end
                if (jd_more) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_jd + AW'(1);
                    n_jd      = r_jd + AW'(1);
                end
            end
            lsx_pkg::ST_SRT_WRI: begin
                mem_we    = 1'b1;
                mem_waddr = r_i;
                mem_wdata = r_a;
                n_i       = r_i + AW'(1);
            end
            lsx_pkg::ST_SHOW: begin
                n_strobe = 1'b1;
                n_item   = rd_data;
                n_last   = k_last;
                if (!k_last) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_k + AW'(1);
                    n_k       = r_k + AW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= lsx_pkg::ST_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i     <= n_i;
        r_jd    <= n_jd;
        r_k     <= n_k;
        r_a     <= n_a;
        r_item  <= n_item;
        r_last  <= n_last;
        r_empty <= n_empty;
        r_full  <= n_full;
    end

    assign o_strobe    = r_strobe;
    assign o_item      = r_item;
    assign o_last      = r_last;
    assign o_empty_res = r_empty;
    assign o_full_res  = r_full;

endmodule

>>> sv/lsx_mem.sv
// ----------------------------------------------------------------------------
// lsx_mem
// entry store: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module lsx_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_waddr,
    input  logic [lsx_pkg::DATA_W-1:0] i_wdata,
    input  logic                       i_re,
    input  logic [AW-1:0]              i_raddr,
    output logic [lsx_pkg::DATA_W-1:0] o_rdata
);

    logic [lsx_pkg::DATA_W-1:0] mem [DEPTH];
    logic [lsx_pkg::DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
